FILE: sv/dla_pkg.sv
// ----------------------------------------------------------------------------
// dla_pkg
// Shared types and constants of the delay line audio effects block.
// ----------------------------------------------------------------------------
package dla_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned COEF_W     = 18;
  localparam int unsigned DELAY_W    = 14;
  localparam int unsigned CLIP_W     = 15;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;
  localparam int unsigned PROD_W     = COEF_W + SAMPLE_W;
  localparam int unsigned ACC_W      = PROD_W + 3;
  localparam int unsigned FRAC_W     = 14;
  localparam int unsigned Q_W        = ACC_W - FRAC_W;

  // steps of the delay reduction, enough for any depth of at least four
  localparam int unsigned RED_STEPS  = 12;
  localparam int unsigned RED_CNT_W  = 4;

  localparam logic [DELAY_W-1:0]       RST_DELAY = DELAY_W'(13230);
  localparam logic signed [COEF_W-1:0] RST_COEF_C = COEF_W'(16384);
  localparam logic [CLIP_W-1:0]        RST_CLIP = CLIP_W'(163);

  typedef enum logic [MODE_W-1:0] {
    MODE_PASS,
    MODE_FIR_ECHO,
    MODE_IIR_ECHO,
    MODE_NAT_ECHO,
    MODE_REVERB,
    MODE_BIQUAD,
    MODE_FUZZ
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE,
    REG_DELAY,
    REG_COEF_C,
    REG_COEF_P1,
    REG_COEF_P2,
    REG_COEF_O1,
    REG_COEF_O2,
    REG_CLIP
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ1,
    ST_READ2,
    ST_SUM,
    ST_DONE
  } state_t;

  typedef struct packed {
    mode_t                     mode;
    logic signed [COEF_W-1:0]  coef_c;
    logic signed [COEF_W-1:0]  coef_p1;
    logic signed [COEF_W-1:0]  coef_p2;
    logic signed [COEF_W-1:0]  coef_o1;
    logic signed [COEF_W-1:0]  coef_o2;
    logic [CLIP_W-1:0]         clip;
  } cfg_t;

  typedef struct packed {
    state_t st;
    logic   fwd;
  } mac_ctrl_t;

endpackage

FILE: sv/dla_in_if.sv
// ----------------------------------------------------------------------------
// dla_in_if
// Input sample channel: valid, ready and one signed sample.
// ----------------------------------------------------------------------------
interface dla_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [dla_pkg::SAMPLE_W-1:0]    sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

FILE: sv/dla_out_if.sv
// ----------------------------------------------------------------------------
// dla_out_if
// Result sample channel: valid, ready and one signed sample.
// ----------------------------------------------------------------------------
interface dla_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [dla_pkg::SAMPLE_W-1:0]    sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

FILE: sv/delay_line_audio_effects.sv
// ----------------------------------------------------------------------------
// delay_line_audio_effects
// Echo, reverb, biquad and fuzz effects and a pass-through over circular
// input and output histories.
// ----------------------------------------------------------------------------
// Each sample passes through the states READ1, READ2, SUM and DONE from
// acceptance to its result, and a new sample is taken in the cycle its
// predecessor's result is registered, not before; DONE holds while the output
// is stalled. This pace is set by the two history reads each effect may need
// from each memory's single read port, followed by the multiply-accumulate
// and the write-back of the output. After reset and after every write of
// effect_mode both histories are cleared, one entry per cycle; a write of
// delay_len starts an iterative reduction of the delay modulo the depth. No
// sample is taken during either.
module delay_line_audio_effects #(
  parameter int unsigned HISTORY_DEPTH = 32768
) (
  input  logic                             clk,
  input  logic                             rst_n,
  dla_in_if.sink                           in_chan,
  dla_out_if.source                        out_chan,
  input  logic                             cfg_we,
  input  logic [dla_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [dla_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import dla_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW:0]   DEPTH_C = (AW + 1)'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(HISTORY_DEPTH - 1);
  localparam logic [AW-1:0] ONE     = AW'(1);
  localparam logic [AW-1:0] TWO     = AW'(2);

  cfg_t                       cfg;
  logic [AW-1:0]              nmod, n2mod;
  logic                       busy, clr_req;
  state_t                     st_r, st_nxt;
  logic [AW-1:0]              wp_r, wp_nxt;
  logic [AW-1:0]              clr_cnt_r, clr_cnt_nxt;
  logic                       fwd_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [SAMPLE_W-1:0] y;
  logic [SAMPLE_W-1:0]        in_rd, out_rd;
  logic                       out_ok, y_fire, accept, clearing;
  logic [AW-1:0]              in_off1, in_off2, out_off1, out_off2;
  logic [AW-1:0]              ia1, ia2, oa1, oa2;
  logic                       in_we, out_we;
  logic [AW-1:0]              in_waddr, out_waddr, in_raddr, out_raddr;
  logic [SAMPLE_W-1:0]        in_wdata, out_wdata;
  mac_ctrl_t                  mac_ctrl;

  function automatic logic [AW-1:0] back(input logic [AW-1:0] p,
                                         input logic [AW-1:0] d);
    logic [AW:0] diff;
    diff = {1'b0, p} - {1'b0, d};
    if (diff[AW]) begin
      diff = diff + DEPTH_C;
    end
    return diff[AW-1:0];
  endfunction

  dla_regs #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .nmod      (nmod),
    .n2mod     (n2mod),
    .busy      (busy),
    .clr_req   (clr_req)
  );

  // handshake
  assign out_ok           = !out_valid_r || out_chan.ready;
  assign y_fire           = (st_r == ST_DONE) && out_ok;
  assign in_chan.ready    = !busy && ((st_r == ST_IDLE) || y_fire);
  assign accept           = in_chan.valid && in_chan.ready;
  assign out_chan.valid   = out_valid_r;
  assign out_chan.sample_out = out_sample_r;
  assign clearing         = (st_r == ST_CLEAR);

  // tap distances per mode
  always_comb begin
    in_off1  = nmod;
    in_off2  = n2mod;
    out_off1 = nmod;
    out_off2 = nmod;
    case (cfg.mode)
      MODE_NAT_ECHO: begin
        in_off1  = ONE;
        out_off1 = ONE;
      end
      MODE_BIQUAD: begin
        in_off1  = ONE;
        in_off2  = TWO;
        out_off1 = ONE;
        out_off2 = TWO;
      end
      default: ;
    endcase
  end

  assign ia1 = back(wp_r, in_off1);
  assign ia2 = back(wp_r, in_off2);
  assign oa1 = back(wp_r, out_off1);
  assign oa2 = back(wp_r, out_off2);

  assign in_raddr  = (st_r == ST_READ1) ? ia1 : ia2;
  assign out_raddr = (st_r == ST_READ1) ? oa1 : oa2;

  // x lands in the input history during the first read cycle
  assign in_we     = clearing || (st_r == ST_READ1);
  assign in_waddr  = clearing ? clr_cnt_r : wp_r;
  assign in_wdata  = clearing ? '0 : x_r;
  assign out_we    = clearing || y_fire;
  assign out_waddr = clearing ? clr_cnt_r : wp_r;
  assign out_wdata = clearing ? '0 : y;

  dla_ram #(.DEPTH(HISTORY_DEPTH), .DW(SAMPLE_W)) u_in_hist (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_waddr),
    .wdata (in_wdata),
    .raddr (in_raddr),
    .rdata (in_rd)
  );

  dla_ram #(.DEPTH(HISTORY_DEPTH), .DW(SAMPLE_W)) u_out_hist (
    .clk   (clk),
    .we    (out_we),
    .waddr (out_waddr),
    .wdata (out_wdata),
    .raddr (out_raddr),
    .rdata (out_rd)
  );

  assign mac_ctrl.st  = st_r;
  assign mac_ctrl.fwd = fwd_r;

  dla_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .cfg    (cfg),
    .x      (x_r),
    .in_rd  ($signed(in_rd)),
    .out_rd ($signed(out_rd)),
    .y      (y)
  );

  always_comb begin
    st_nxt      = st_r;
    wp_nxt      = wp_r;
    clr_cnt_nxt = clr_cnt_r;
    case (st_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ONE;
        if (clr_cnt_r == LAST) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          st_nxt = ST_READ1;
        end
      end
      ST_READ1: st_nxt = ST_READ2;
      ST_READ2: st_nxt = ST_SUM;
      ST_SUM:   st_nxt = ST_DONE;
      ST_DONE: begin
        if (y_fire) begin
          wp_nxt = (wp_r == LAST) ? '0 : wp_r + ONE;
          st_nxt = accept ? ST_READ1 : ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (clr_req) begin
      st_nxt      = ST_CLEAR;
      wp_nxt      = '0;
      clr_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      wp_r        <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      wp_r      <= wp_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (y_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= in_chan.sample_in;
    end
    if (y_fire) begin
      out_sample_r <= y;
    end
    // first input tap at the write slot sees x, written in that same cycle
    if (st_r == ST_READ1) begin
      fwd_r <= (ia1 == wp_r);
    end
  end

endmodule

FILE: sv/dla_regs.sv
// ----------------------------------------------------------------------------
// dla_regs
// Configuration registers and the iterative reduction of the delay modulo
// the history depth.
// ----------------------------------------------------------------------------
module dla_regs #(
  parameter int unsigned HISTORY_DEPTH = 32768
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dla_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [dla_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output dla_pkg::cfg_t                       cfg,
  output logic [$clog2(HISTORY_DEPTH)-1:0]    nmod,
  output logic [$clog2(HISTORY_DEPTH)-1:0]    n2mod,
  output logic                                busy,
  output logic                                clr_req
);
  import dla_pkg::*;

  localparam int unsigned AW   = $clog2(HISTORY_DEPTH);
  localparam int unsigned DSHW = AW + 1 + RED_STEPS;
  localparam logic [DSHW-1:0] DEPTH_C  = DSHW'(HISTORY_DEPTH);
  localparam logic [DSHW-1:0] DSH_INIT = DEPTH_C << (RED_STEPS - 1);

  cfg_t                 cfg_r;
  logic [DELAY_W-1:0]   red_r;
  logic [DSHW-1:0]      dsh_r;
  logic [RED_CNT_W-1:0] red_cnt_r;
  logic [AW-1:0]        n2mod_r;
  logic [DSHW-1:0]      red_ext;
  logic [DSHW-1:0]      twice;
  logic [DSHW-1:0]      twice_mod;

  assign red_ext   = DSHW'(red_r);
  assign twice     = red_ext << 1;
  assign twice_mod = (twice >= DEPTH_C) ? (twice - DEPTH_C) : twice;

  assign cfg     = cfg_r;
  assign nmod    = red_ext[AW-1:0];
  assign n2mod   = n2mod_r;
  assign busy    = (red_cnt_r != '0);
  assign clr_req = cfg_we && (cfg_reg_t'(cfg_idx) == REG_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode    <= MODE_PASS;
      cfg_r.coef_c  <= RST_COEF_C;
      cfg_r.coef_p1 <= '0;
      cfg_r.coef_p2 <= '0;
      cfg_r.coef_o1 <= '0;
      cfg_r.coef_o2 <= '0;
      cfg_r.clip    <= RST_CLIP;
      red_r         <= RST_DELAY;
      dsh_r         <= DSH_INIT;
      red_cnt_r     <= RED_CNT_W'(RED_STEPS + 1);
      n2mod_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_MODE:    cfg_r.mode    <= mode_t'(cfg_wdata[MODE_W-1:0]);
        REG_DELAY: begin
          red_r     <= cfg_wdata[DELAY_W-1:0];
          dsh_r     <= DSH_INIT;
          red_cnt_r <= RED_CNT_W'(RED_STEPS + 1);
        end
        REG_COEF_C:  cfg_r.coef_c  <= cfg_wdata[COEF_W-1:0];
        REG_COEF_P1: cfg_r.coef_p1 <= cfg_wdata[COEF_W-1:0];
        REG_COEF_P2: cfg_r.coef_p2 <= cfg_wdata[COEF_W-1:0];
        REG_COEF_O1: cfg_r.coef_o1 <= cfg_wdata[COEF_W-1:0];
        REG_COEF_O2: cfg_r.coef_o2 <= cfg_wdata[COEF_W-1:0];
        REG_CLIP:    cfg_r.clip    <= cfg_wdata[CLIP_W-1:0];
        default: ;
      endcase
    end else if (red_cnt_r > RED_CNT_W'(1)) begin
      // restoring reduction, one shifted depth per cycle while no register is written
      if (red_ext >= dsh_r) begin
        red_r <= red_r - dsh_r[DELAY_W-1:0];
      end
      dsh_r     <= dsh_r >> 1;
      red_cnt_r <= red_cnt_r - RED_CNT_W'(1);
    end else if (red_cnt_r == RED_CNT_W'(1)) begin
      n2mod_r   <= twice_mod[AW-1:0];
      red_cnt_r <= '0;
    end
  end

endmodule

FILE: sv/dla_ram.sv
// ----------------------------------------------------------------------------
// dla_ram
// Simple dual port history memory, one write and one registered read.
// ----------------------------------------------------------------------------
module dla_ram #(
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned DW    = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/dla_mac.sv
// ----------------------------------------------------------------------------
// dla_mac
// Two multiply lanes and an accumulator, then rounding and saturation.
// ----------------------------------------------------------------------------
module dla_mac (
  input  logic                               clk,
  input  dla_pkg::mac_ctrl_t                 ctrl,
  input  dla_pkg::cfg_t                      cfg,
  input  logic signed [dla_pkg::SAMPLE_W-1:0] x,
  input  logic signed [dla_pkg::SAMPLE_W-1:0] in_rd,
  input  logic signed [dla_pkg::SAMPLE_W-1:0] out_rd,
  output logic signed [dla_pkg::SAMPLE_W-1:0] y
);
  import dla_pkg::*;

  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1 << (FRAC_W - 1));
  localparam int unsigned XW = ACC_W - PROD_W;

  logic signed [PROD_W-1:0]   prod_a_r;
  logic signed [PROD_W-1:0]   prod_b_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [PROD_W-1:0]   prod_a_nxt;
  logic signed [PROD_W-1:0]   prod_b_nxt;
  logic signed [COEF_W-1:0]   coef_a;
  logic signed [COEF_W-1:0]   coef_b;
  logic signed [SAMPLE_W-1:0] data_a;
  logic signed [COEF_W-1:0]   ca1, ca2, cb1, cb2;
  logic signed [SAMPLE_W:0]   x_ext, lim, nlim;
  logic signed [SAMPLE_W-1:0] x_clip;
  logic signed [ACC_W-1:0]    a_ext, b_ext, sum;
  logic signed [Q_W-1:0]      q;
  logic signed [SAMPLE_W-1:0] sat;
  logic                       pass;

  // tap gains that each mode uses, zero for unused taps
  always_comb begin
    ca1  = '0;
    ca2  = '0;
    cb1  = '0;
    cb2  = '0;
    pass = 1'b0;
    case (cfg.mode)
      MODE_FIR_ECHO: begin
        ca1 = cfg.coef_p1;
        ca2 = cfg.coef_p2;
      end
      MODE_IIR_ECHO: cb1 = cfg.coef_o1;
      MODE_NAT_ECHO: begin
        ca1 = cfg.coef_p1;
        cb1 = cfg.coef_o1;
        cb2 = cfg.coef_o2;
      end
      MODE_REVERB: begin
        ca1 = cfg.coef_p1;
        cb1 = cfg.coef_o1;
      end
      MODE_BIQUAD: begin
        ca1 = cfg.coef_p1;
        ca2 = cfg.coef_p2;
        cb1 = cfg.coef_o1;
        cb2 = cfg.coef_o2;
      end
      MODE_FUZZ: ;
      default: pass = 1'b1;
    endcase
  end

  // fuzz clipping to the symmetric limit
  always_comb begin
    x_ext = {x[SAMPLE_W-1], x};
    lim   = $signed({2'b00, cfg.clip});
    nlim  = -lim;
    if (x_ext > lim) begin
      x_clip = lim[SAMPLE_W-1:0];
    end else if (x_ext < nlim) begin
      x_clip = nlim[SAMPLE_W-1:0];
    end else begin
      x_clip = x;
    end
  end

  always_comb begin
    coef_a = '0;
    coef_b = '0;
    data_a = in_rd;
    case (ctrl.st)
      ST_READ1: begin
        coef_a = cfg.coef_c;
        data_a = (cfg.mode == MODE_FUZZ) ? x_clip : x;
      end
      ST_READ2: begin
        coef_a = ca1;
        coef_b = cb1;
        data_a = ctrl.fwd ? x : in_rd;
      end
      ST_SUM: begin
        coef_a = ca2;
        coef_b = cb2;
      end
      default: ;
    endcase
    prod_a_nxt = coef_a * data_a;
    prod_b_nxt = coef_b * out_rd;
  end

  assign a_ext = {{XW{prod_a_r[PROD_W-1]}}, prod_a_r};
  assign b_ext = {{XW{prod_b_r[PROD_W-1]}}, prod_b_r};

  always_ff @(posedge clk) begin
    if (ctrl.st == ST_READ1 || ctrl.st == ST_READ2 || ctrl.st == ST_SUM) begin
      prod_a_r <= prod_a_nxt;
      prod_b_r <= prod_b_nxt;
    end
    if (ctrl.st == ST_READ2) begin
      acc_r <= a_ext + RND;
    end else if (ctrl.st == ST_SUM) begin
      acc_r <= acc_r + a_ext + b_ext;
    end
  end

  // rounding offset already sits in the accumulator
  always_comb begin
    sum = acc_r + a_ext + b_ext;
    q   = sum[ACC_W-1:FRAC_W];
    if (!q[Q_W-1] && (|q[Q_W-2:SAMPLE_W-1])) begin
      sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (q[Q_W-1] && !(&q[Q_W-2:SAMPLE_W-1])) begin
      sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat = q[SAMPLE_W-1:0];
    end
    y = pass ? x : sat;
  end

endmodule
